// ===== hw/rtl/brms_pkg.sv =====
// Package for the block RMS meter: beat types, widths and shared constants.
package brms_pkg;

  localparam int MaxSamples = 1024;
  localparam int SampleW    = 16;
  localparam int SqW        = 31;
  localparam int CntW       = $clog2(MaxSamples + 1);
  localparam int SumW       = SqW + $clog2(MaxSamples);
  localparam int QuoW       = SqW;
  localparam int RmsW       = 16;
  localparam int CountOutW  = 11;
  localparam int SubW       = 32;
  localparam int StepW      = $clog2(SumW);

  typedef struct packed {
    logic signed [SampleW-1:0] sample_value;
    logic                      last_sample;
  } in_t;

  typedef struct packed {
    logic [RmsW-1:0]      rms_value;
    logic [CountOutW-1:0] sample_count;
    logic                 count_overflow;
  } out_t;

  typedef struct packed {
    logic start;
    logic ack;
  } calc_req_t;

  typedef struct packed {
    logic            done;
    logic [RmsW-1:0] root;
  } calc_stat_t;

endpackage

// ===== hw/rtl/block_rms_meter.sv =====
// Block RMS meter top level: square accumulator, result register and engine control.
//
//  channel | dir | handshake             | beat
//  in      | in  | in_valid_i/in_stall_o | in_i  (sample_value, last_sample)
//  out     | out | out_valid_o/out_stall_i| out_o (rms_value, sample_count, count_overflow)
//
// Unmarked samples are taken one per cycle while not stalled; the square is registered and
// then summed. A marked sample passes the flush state, SumW (41) divide steps and 16
// root steps on the shared subtractor, then the result loads once the output register is free.
// in_stall_o is high from the marked sample until the result is loaded.
// Reset clears the accumulator, the sample counter and both valid flags.
module block_rms_meter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  brms_pkg::in_t   in_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output brms_pkg::out_t  out_o
);
  import brms_pkg::*;

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_CALC  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [SqW-1:0]       sq_q, sq_d;
  logic                 sq_vld_q, sq_vld_d;
  logic [SumW-1:0]      sum_q, sum_d, sum_add;
  logic [CntW-1:0]      seen_q, seen_d;
  logic                 ovf_q, ovf_d;
  logic [CountOutW-1:0] res_cnt_q, res_cnt_d;
  logic                 res_ovf_q, res_ovf_d;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_q, out_d;

  logic                 acc, full, out_free;
  logic [SampleW-1:0]   mag;
  logic [2*SampleW-1:0] prod;
  calc_req_t            req;
  calc_stat_t           stat;

  assign in_stall_o = (state_q != ST_RUN);
  assign acc        = in_valid_i && !in_stall_o;
  assign full       = (seen_q == CntW'(MaxSamples));
  assign mag        = in_i.sample_value[SampleW-1] ? (~in_i.sample_value + 1'b1)
                                                   : in_i.sample_value;
  assign prod       = mag * mag;
  assign sum_add    = sum_q + (sq_vld_q ? SumW'(sq_q) : SumW'(0));
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    sq_d        = sq_q;
    sq_vld_d    = 1'b0;
    sum_d       = sum_add;
    seen_d      = seen_q;
    ovf_d       = ovf_q;
    res_cnt_d   = res_cnt_q;
    res_ovf_d   = res_ovf_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    req.start   = 1'b0;
    req.ack     = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        if (acc) begin
          if (!full) begin
            sq_d     = prod[SqW-1:0];
            sq_vld_d = 1'b1;
            seen_d   = seen_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last_sample) state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        req.start = 1'b1;
        res_cnt_d = CountOutW'(seen_q);
        res_ovf_d = ovf_q;
        sum_d     = '0;
        seen_d    = '0;
        ovf_d     = 1'b0;
        state_d   = ST_CALC;
      end
      ST_CALC: begin
        if (stat.done && out_free) begin
          req.ack              = 1'b1;
          out_d.rms_value      = stat.root;
          out_d.sample_count   = res_cnt_q;
          out_d.count_overflow = res_ovf_q;
          out_valid_d          = 1'b1;
          state_d              = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      sq_vld_q    <= 1'b0;
      sum_q       <= '0;
      seen_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sq_vld_q    <= sq_vld_d;
      sum_q       <= sum_d;
      seen_q      <= seen_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q      <= sq_d;
    res_cnt_q <= res_cnt_d;
    res_ovf_q <= res_ovf_d;
    out_q     <= out_d;
  end

  brms_calc u_calc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .sum_i  (sum_add),
    .div_i  (seen_q),
    .stat_o (stat)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= CntW'(MaxSamples))
    else $error("sample count beyond maximum");

  a_flush_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLUSH |-> seen_q != '0)
    else $error("empty block reaches divider");

  a_no_sq_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CALC |-> !sq_vld_q && sum_q == '0)
    else $error("accumulator not cleared during calculation");

endmodule

// ===== hw/rtl/brms_calc.sv =====
// Mean and square root engine: restoring divide then bitwise isqrt on one subtractor.
module brms_calc (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  brms_pkg::calc_req_t         req_i,
  input  logic [brms_pkg::SumW-1:0]   sum_i,
  input  logic [brms_pkg::CntW-1:0]   div_i,
  output brms_pkg::calc_stat_t        stat_o
);
  import brms_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_ROOT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [SumW-1:0] dq_q, dq_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic [CntW-1:0] div_q, div_d;
  logic [QuoW-1:0] v_q, v_d;
  logic [QuoW-1:0] root_q, root_d;
  logic [QuoW-1:0] bit_q, bit_d;

  logic [SubW-1:0] op_a, op_b;
  logic [SubW:0]   diff;
  logic            ge;

  // shared subtract/compare unit
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_q == S_DIV) begin
      op_a = SubW'({rem_q, dq_q[SumW-1]});
      op_b = SubW'(div_q);
    end else begin
      op_a = SubW'(v_q);
      op_b = SubW'(root_q | bit_q);
    end
  end

  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign ge   = ~diff[SubW];

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    dq_d    = dq_q;
    rem_d   = rem_q;
    div_d   = div_q;
    v_d     = v_q;
    root_d  = root_q;
    bit_d   = bit_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          dq_d    = sum_i;
          div_d   = div_i;
          rem_d   = '0;
          step_d  = StepW'(SumW - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d  = ge ? diff[CntW-1:0] : {rem_q[CntW-2:0], dq_q[SumW-1]};
        dq_d   = {dq_q[SumW-2:0], ge};
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          v_d     = dq_d[QuoW-1:0];
          root_d  = '0;
          bit_d   = {1'b1, {(QuoW-1){1'b0}}};
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        if (ge) begin
          v_d    = diff[QuoW-1:0];
          root_d = (root_q >> 1) | bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) state_d = S_DONE;
      end
      S_DONE: begin
        if (req_i.ack) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    v_q    <= v_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign stat_o.done = (state_q == S_DONE);
  assign stat_o.root = root_q[RmsW-1:0];

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < div_q)
    else $error("remainder not below divisor");

  a_bit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROOT |-> $onehot(bit_q))
    else $error("root trial bit not one-hot");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> root_q <= QuoW'(32768))
    else $error("root out of range");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == S_IDLE)
    else $error("start while engine busy");

endmodule
